FILE: src/bal_pkg.sv
// ----------------------------------------------------------------------------
// bal_pkg
// shared widths, defaults and control types for the buddy allocator
// ----------------------------------------------------------------------------
package bal_pkg;

  localparam int MAX_LOG_DEF = 20;
  localparam int MIN_LOG_DEF = 5;

  // level values reach 21 from the size field and 32 from the parameter range
  localparam int LVL_W   = 6;
  localparam int SIZE_W  = 21;
  localparam int OFF_W   = 20;
  localparam int CFG_W   = 5;
  localparam int CFG_RST = 20;

  typedef struct packed {
    logic we_next;
    logic we_prev;
    logic we_mark;
  } bal_mem_ctl_t;

endpackage

FILE: src/bal_if.sv
// ----------------------------------------------------------------------------
// bal_if
// request, result and configuration channels of the buddy allocator
// ----------------------------------------------------------------------------
interface bal_in_if import bal_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              mode;
  logic [SIZE_W-1:0] request_size;
  logic [OFF_W-1:0]  block_offset;
  modport source (output valid, mode, request_size, block_offset, input ready);
  modport sink   (input valid, mode, request_size, block_offset, output ready);
endinterface

interface bal_out_if import bal_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             ok;
  logic [OFF_W-1:0] result_offset;
  modport source (output valid, ok, result_offset, input ready);
  modport sink   (input valid, ok, result_offset, output ready);
endinterface

interface bal_cfg_if import bal_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] pool_log;
  modport source (output valid, pool_log, input ready);
  modport sink   (input valid, pool_log, output ready);
endinterface

FILE: src/bal_node_mem.sv
// ----------------------------------------------------------------------------
// bal_node_mem
// per-block link and free-mark memories, one shared address, registered read
// ----------------------------------------------------------------------------
module bal_node_mem import bal_pkg::*; #(
  parameter int BW = MAX_LOG_DEF - MIN_LOG_DEF
) (
  input  logic            clk,
  input  logic [BW-1:0]   addr,
  input  bal_mem_ctl_t    ctl,
  input  logic [BW:0]     wnext,
  input  logic [BW:0]     wprev,
  input  logic [LVL_W:0]  wmark,
  output logic [BW:0]     rnext,
  output logic [BW:0]     rprev,
  output logic [LVL_W:0]  rmark
);

  localparam int NBLK = 1 << BW;

  // next link + next valid
  logic [BW:0]    next_mem [NBLK];
  // prev link + prev is head
  logic [BW:0]    prev_mem [NBLK];
  // free bit + level
  logic [LVL_W:0] mark_mem [NBLK];

  always_ff @(posedge clk) begin
    if (ctl.we_next) begin
      next_mem[addr] <= wnext;
    end
    rnext <= next_mem[addr];
  end

  always_ff @(posedge clk) begin
    if (ctl.we_prev) begin
      prev_mem[addr] <= wprev;
    end
    rprev <= prev_mem[addr];
  end

  always_ff @(posedge clk) begin
    if (ctl.we_mark) begin
      mark_mem[addr] <= wmark;
    end
    rmark <= mark_mem[addr];
  end

endmodule

FILE: src/buddy_allocator.sv
// ----------------------------------------------------------------------------
// buddy_allocator
// binary buddy allocator with free lists in block memories
// ----------------------------------------------------------------------------
// One request at a time. An allocate or free request is first transferred and
// then runs the size-level shift loop (S_LVL). Allocate then scans the free-list
// heads one level a cycle, up to the level above pool_log, which finds nothing;
// it unlinks the head (S_U1, S_U2, S_U3) and splits level by level (S_SPLIT,
// S_LF1, S_LF2). Free links the block (S_LF1, S_LF2), and each merge step is a
// buddy mark read (S_FCHK, S_FM), two unlinks and a relink. Every step goes
// through the single-port node memories. The result is handed to the output
// register in S_DONE, which waits while that register is still held. After
// reset and after each pool_log write the free marks are swept and the pool is
// linked as one free block, during which no request is taken.
module buddy_allocator import bal_pkg::*; #(
  parameter int MAX_LOG = MAX_LOG_DEF,
  parameter int MIN_LOG = MIN_LOG_DEF
) (
  input logic       clk,
  input logic       rst_n,
  bal_in_if.sink    in_ch,
  bal_out_if.source out_ch,
  bal_cfg_if.sink   cfg_ch
);

  localparam int BW   = MAX_LOG - MIN_LOG;         // block number width
  localparam int HN   = MAX_LOG + 1;               // number of free lists
  localparam int HIW  = $clog2(HN);
  localparam int SW   = SIZE_W - MIN_LOG;          // size shift register
  localparam int AW   = (MAX_LOG > OFF_W) ? MAX_LOG : OFF_W;

  // sequencer states
  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_LVL   = 4'd2;
  localparam logic [3:0] S_SRCH  = 4'd3;
  localparam logic [3:0] S_U1    = 4'd4;
  localparam logic [3:0] S_U2    = 4'd5;
  localparam logic [3:0] S_U3    = 4'd6;
  localparam logic [3:0] S_SPLIT = 4'd7;
  localparam logic [3:0] S_LF1   = 4'd8;
  localparam logic [3:0] S_LF2   = 4'd9;
  localparam logic [3:0] S_FCHK  = 4'd10;
  localparam logic [3:0] S_FM    = 4'd11;
  localparam logic [3:0] S_DONE  = 4'd12;

  // where a link or unlink returns to
  localparam logic [2:0] C_INIT  = 3'd0;
  localparam logic [2:0] C_SPLIT = 3'd1;
  localparam logic [2:0] C_MERGE = 3'd2;
  localparam logic [2:0] C_UALC  = 3'd3;
  localparam logic [2:0] C_UHI   = 3'd4;
  localparam logic [2:0] C_ULO   = 3'd5;

  localparam logic MODE_ALLOC = 1'b0;

  localparam logic [LVL_W-1:0] MIN_L = LVL_W'(MIN_LOG);
  localparam logic [LVL_W-1:0] MAX_L = LVL_W'(MAX_LOG);

  // saturate a written pool size to the supported range
  function automatic logic [LVL_W-1:0] sat_log(input logic [CFG_W-1:0] v);
    logic [LVL_W-1:0] w;
    w = LVL_W'(v);
    if (w < MIN_L) begin
      return MIN_L;
    end
    if (w > MAX_L) begin
      return MAX_L;
    end
    return w;
  endfunction

  logic [3:0]        st_r, st_nxt;
  logic [2:0]        ctx_r, ctx_nxt;
  logic              mode_r, mode_nxt;
  logic [LVL_W-1:0]  pool_r, pool_nxt;
  logic [SW-1:0]     sz_r, sz_nxt;
  logic [LVL_W-1:0]  tgt_r, tgt_nxt;       // requested level
  logic [LVL_W-1:0]  l_r, l_nxt;           // working level
  logic [BW-1:0]     blk_r, blk_nxt;       // base block of the request
  logic [BW-1:0]     lb_r, lb_nxt;         // block being linked or unlinked
  logic [OFF_W-1:0]  off_r, off_nxt;       // raw free offset, then echo
  logic [BW-1:0]     h_r, h_nxt;
  logic              hv_r, hv_nxt;
  logic [BW-1:0]     n_r, n_nxt;
  logic              nv_r, nv_nxt;
  logic [BW-1:0]     p_r, p_nxt;
  logic              ph_r, ph_nxt;
  logic [BW-1:0]     clr_r, clr_nxt;
  logic              rok_r, rok_nxt;
  logic [OFF_W-1:0]  roff_r, roff_nxt;
  logic              ov_r, ov_nxt;
  logic              ook_r, ook_nxt;
  logic [OFF_W-1:0]  ooff_r, ooff_nxt;

  // free-list heads with a valid bit per level
  logic [BW-1:0]     head_r [HN];
  logic [HN-1:0]     headv_r, headv_nxt;
  logic              head_we;
  logic [HIW-1:0]    head_wi;
  logic [BW-1:0]     head_wd;

  // node memory port
  logic [BW-1:0]     ma;
  bal_mem_ctl_t      mctl;
  logic [BW:0]       wnext, wprev, rnext, rprev;
  logic [LVL_W:0]    wmark, rmark;

  logic [HIW-1:0]    li;
  logic [SIZE_W-1:0] size_m1;
  logic [LVL_W-1:0]  flv;
  logic [OFF_W-1:0]  fmask;
  logic [OFF_W-1:0]  foff;
  logic [AW-1:0]     foff_w;
  logic [AW-1:0]     res_w;
  logic [BW-1:0]     bud;

  assign li      = l_r[HIW-1:0];
  assign size_m1 = in_ch.request_size - SIZE_W'(1);
  assign flv     = (tgt_r > pool_r) ? pool_r : tgt_r;
  assign foff_w  = AW'(foff);
  assign res_w   = AW'({blk_r, {MIN_LOG{1'b0}}});
  assign bud     = blk_r ^ (BW'(1) << (l_r - MIN_L));

  // offset kept inside the pool and aligned to the block level
  always_comb begin
    for (int i = 0; i < OFF_W; i++) begin
      fmask[i] = (LVL_W'(i) < pool_r) && (LVL_W'(i) >= flv);
    end
    foff = off_r & fmask;
  end

  assign in_ch.ready   = (st_r == S_IDLE);
  assign cfg_ch.ready  = 1'b1;
  assign out_ch.valid  = ov_r;
  assign out_ch.ok     = ook_r;
  assign out_ch.result_offset = ooff_r;

  always_comb begin
    st_nxt    = st_r;
    ctx_nxt   = ctx_r;
    mode_nxt  = mode_r;
    pool_nxt  = pool_r;
    sz_nxt    = sz_r;
    tgt_nxt   = tgt_r;
    l_nxt     = l_r;
    blk_nxt   = blk_r;
    lb_nxt    = lb_r;
    off_nxt   = off_r;
    h_nxt     = h_r;
    hv_nxt    = hv_r;
    n_nxt     = n_r;
    nv_nxt    = nv_r;
    p_nxt     = p_r;
    ph_nxt    = ph_r;
    clr_nxt   = clr_r;
    rok_nxt   = rok_r;
    roff_nxt  = roff_r;
    ov_nxt    = ov_r;
    ook_nxt   = ook_r;
    ooff_nxt  = ooff_r;
    headv_nxt = headv_r;
    head_we   = 1'b0;
    head_wi   = li;
    head_wd   = lb_r;
    ma        = lb_r;
    mctl      = '0;
    wnext     = {h_r, hv_r};
    wprev     = {lb_r, 1'b1};
    wmark     = {1'b1, l_r};

    if (ov_r && out_ch.ready) begin
      ov_nxt = 1'b0;
    end

    case (st_r)
      S_CLR: begin
        // sweep every free mark clear, then make the whole pool one free block
        ma           = clr_r;
        mctl.we_mark = 1'b1;
        wmark        = '0;
        clr_nxt      = clr_r + BW'(1);
        if (clr_r == {BW{1'b1}}) begin
          lb_nxt  = '0;
          l_nxt   = pool_r;
          ctx_nxt = C_INIT;
          st_nxt  = S_LF1;
        end
      end
      S_IDLE: begin
        if (in_ch.valid) begin
          mode_nxt = in_ch.mode;
          sz_nxt   = (in_ch.request_size == '0) ? '0 : size_m1[SIZE_W-1:MIN_LOG];
          off_nxt  = in_ch.block_offset;
          tgt_nxt  = MIN_L;
          st_nxt   = S_LVL;
        end
      end
      S_LVL: begin
        // round the size up to a power of two, one bit a cycle
        if (sz_r != '0) begin
          sz_nxt  = sz_r >> 1;
          tgt_nxt = tgt_r + LVL_W'(1);
        end else if (mode_r == MODE_ALLOC) begin
          l_nxt  = tgt_r;
          st_nxt = S_SRCH;
        end else begin
          off_nxt = foff;
          blk_nxt = foff_w[MIN_LOG +: BW];
          lb_nxt  = foff_w[MIN_LOG +: BW];
          l_nxt   = flv;
          ctx_nxt = C_MERGE;
          st_nxt  = S_LF1;
        end
      end
      S_SRCH: begin
        if (l_r > pool_r) begin
          rok_nxt  = 1'b0;
          roff_nxt = '0;
          st_nxt   = S_DONE;
        end else if (headv_r[li]) begin
          blk_nxt = head_r[li];
          lb_nxt  = head_r[li];
          ctx_nxt = C_UALC;
          st_nxt  = S_U1;
        end else begin
          l_nxt = l_r + LVL_W'(1);
        end
      end
      S_U1: begin
        // read the links; an allocated or absorbed block loses its free mark
        ma = lb_r;
        if (ctx_r == C_UALC || ctx_r == C_UHI) begin
          mctl.we_mark = 1'b1;
          wmark        = {1'b0, l_r};
        end
        st_nxt = S_U2;
      end
      S_U2: begin
        n_nxt  = rnext[BW:1];
        nv_nxt = rnext[0];
        p_nxt  = rprev[BW:1];
        ph_nxt = rprev[0];
        if (rprev[0]) begin
          head_we       = 1'b1;
          head_wd       = rnext[BW:1];
          headv_nxt[li] = rnext[0];
        end else begin
          ma           = rprev[BW:1];
          mctl.we_next = 1'b1;
          wnext        = rnext;
        end
        st_nxt = S_U3;
      end
      S_U3: begin
        if (nv_r) begin
          ma           = n_r;
          mctl.we_prev = 1'b1;
          wprev        = {p_r, ph_r};
        end
        case (ctx_r)
          C_UALC: begin
            st_nxt = S_SPLIT;
          end
          C_UHI: begin
            lb_nxt  = blk_r;
            ctx_nxt = C_ULO;
            st_nxt  = S_U1;
          end
          default: begin
            // both halves gone: relink the joined block a level up
            lb_nxt  = blk_r;
            l_nxt   = l_r + LVL_W'(1);
            ctx_nxt = C_MERGE;
            st_nxt  = S_LF1;
          end
        endcase
      end
      S_SPLIT: begin
        if (l_r > tgt_r) begin
          l_nxt   = l_r - LVL_W'(1);
          lb_nxt  = blk_r | (BW'(1) << (l_r - LVL_W'(1) - MIN_L));
          ctx_nxt = C_SPLIT;
          st_nxt  = S_LF1;
        end else begin
          rok_nxt  = 1'b1;
          roff_nxt = res_w[OFF_W-1:0];
          st_nxt   = S_DONE;
        end
      end
      S_LF1: begin
        // push at the front of the list of its level
        ma           = lb_r;
        mctl.we_next = 1'b1;
        mctl.we_prev = 1'b1;
        mctl.we_mark = 1'b1;
        wnext        = {head_r[li], headv_r[li]};
        wprev        = {lb_r, 1'b1};
        wmark        = {1'b1, l_r};
        h_nxt        = head_r[li];
        hv_nxt       = headv_r[li];
        head_we      = 1'b1;
        head_wd      = lb_r;
        headv_nxt[li] = 1'b1;
        st_nxt       = S_LF2;
      end
      S_LF2: begin
        if (hv_r) begin
          ma           = h_r;
          mctl.we_prev = 1'b1;
          wprev        = {lb_r, 1'b0};
        end
        case (ctx_r)
          C_INIT:  st_nxt = S_IDLE;
          C_SPLIT: st_nxt = S_SPLIT;
          default: st_nxt = S_FCHK;
        endcase
      end
      S_FCHK: begin
        if (l_r >= pool_r) begin
          rok_nxt  = 1'b1;
          roff_nxt = off_r;
          st_nxt   = S_DONE;
        end else begin
          ma     = bud;
          lb_nxt = bud;
          st_nxt = S_FM;
        end
      end
      S_FM: begin
        // buddy free at the same level: unlink the upper half, then the lower
        if (rmark[LVL_W] && rmark[LVL_W-1:0] == l_r) begin
          if (lb_r < blk_r) begin
            lb_nxt  = blk_r;
            blk_nxt = lb_r;
          end
          ctx_nxt = C_UHI;
          st_nxt  = S_U1;
        end else begin
          rok_nxt  = 1'b1;
          roff_nxt = off_r;
          st_nxt   = S_DONE;
        end
      end
      S_DONE: begin
        if (!ov_r || out_ch.ready) begin
          ov_nxt   = 1'b1;
          ook_nxt  = rok_r;
          ooff_nxt = roff_r;
          st_nxt   = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase

    // new pool size: clear the lists and sweep the marks again
    if (cfg_ch.valid) begin
      pool_nxt  = sat_log(cfg_ch.pool_log);
      headv_nxt = '0;
      clr_nxt   = '0;
      st_nxt    = S_CLR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_CLR;
      pool_r  <= sat_log(CFG_W'(CFG_RST));
      headv_r <= '0;
      clr_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      pool_r  <= pool_nxt;
      headv_r <= headv_nxt;
      clr_r   <= clr_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ctx_r  <= ctx_nxt;
    mode_r <= mode_nxt;
    sz_r   <= sz_nxt;
    tgt_r  <= tgt_nxt;
    l_r    <= l_nxt;
    blk_r  <= blk_nxt;
    lb_r   <= lb_nxt;
    off_r  <= off_nxt;
    h_r    <= h_nxt;
    hv_r   <= hv_nxt;
    n_r    <= n_nxt;
    nv_r   <= nv_nxt;
    p_r    <= p_nxt;
    ph_r   <= ph_nxt;
    rok_r  <= rok_nxt;
    roff_r <= roff_nxt;
    ook_r  <= ook_nxt;
    ooff_r <= ooff_nxt;
    if (head_we) begin
      head_r[head_wi] <= head_wd;
    end
  end

  bal_node_mem #(
    .BW (BW)
  ) u_mem (
    .clk   (clk),
    .addr  (ma),
    .ctl   (mctl),
    .wnext (wnext),
    .wprev (wprev),
    .wmark (wmark),
    .rnext (rnext),
    .rprev (rprev),
    .rmark (rmark)
  );

endmodule
